/* rtl/jsfx_pkg.sv */
// types, constants and helper functions shared by the json string extractor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jsfx_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_value;
        logic [1:0] end_reason;
    } t_out_item;

    // classified text byte handed from the front to the back
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       hit;
        logic       key_empty;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_tok;

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_COLON,
        PH_QUOTE,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_LOOK,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        END_QUOTE    = 2'd0,
        END_TEXT     = 2'd1,
        END_BADHEX   = 2'd2,
        END_NOTFOUND = 2'd3
    } t_end_reason;

    localparam logic [1:0] CFG_KEY_LO  = 2'd0;
    localparam logic [1:0] CFG_KEY_HI  = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN = 2'd2;

    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HI_SURR_MIN = 16'hd800;
    localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
    localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
    localparam logic [15:0] LO_SURR_MAX = 16'hdfff;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r.b = '0;
        if (cp <= 21'h7f) begin
            r.n    = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            r.n    = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.n    = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // returns {is_hex, value}
    function automatic logic [4:0] hex_class(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

/* rtl/json_string_field_extractor.sv */
// a pushed byte is registered in the token queue, its results in the result buffer
// 1 byte per cycle while not full; a byte's results hold the decoder until popped
// a failed surrogate look-ahead replays (up to 6) bytes, one per cycle if not stalled
// reset: synchronous active-low; clears queues, decoder phase and key registers
// (key length 1, key bytes zero); buffered bytes and results are dropped
`timescale 1ns / 1ps

module json_string_field_extractor import jsfx_pkg::*; #(
    parameter int KEY_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata
);

    logic [63:0] r_key_lo, r_key_hi;
    logic [4:0]  r_key_len;
    logic        accept, q_empty, q_rd;
    t_tok        f_tok, q_tok;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_LO:  r_key_lo  <= i_cfg_wdata;
                CFG_KEY_HI:  r_key_hi  <= i_cfg_wdata;
                CFG_KEY_LEN: r_key_len <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    jsfx_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .i_key_lo  (r_key_lo),
        .i_key_hi  (r_key_hi),
        .i_key_len (r_key_len),
        .o_tok     (f_tok)
    );

    jsfx_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_tok   (f_tok),
        .i_rd    (q_rd),
        .o_tok   (q_tok),
        .o_full  (full),
        .o_empty (q_empty)
    );

    jsfx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (q_tok),
        .i_tok_valid (!q_empty),
        .o_tok_rd    (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

/* rtl/jsfx_front.sv */
// front end: key window, key match and hex classification of each accepted byte
// depends on jsfx_pkg
`timescale 1ns / 1ps

module jsfx_front import jsfx_pkg::*; #(
    parameter int KEY_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [63:0] i_key_lo,
    input  logic [63:0] i_key_hi,
    input  logic [4:0]  i_key_len,
    output t_tok        o_tok
);

    localparam int LW  = $clog2(KEY_BYTES + 1);
    localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [7:0]    r_win [KEY_BYTES];
    logic [7:0]    n_win [KEY_BYTES];
    logic [LW-1:0] r_fill, n_fill;
    logic [7:0]    key_b [KEY_BYTES];
    logic [5:0]    len;
    logic          match;
    logic [5:0]    idx;
    logic [4:0]    hx;

    for (genvar g = 0; g < KEY_BYTES; g++) begin : g_key
        if (g < 8) begin : g_lo
            assign key_b[g] = i_key_lo[8*g +: 8];
        end else if (g < 16) begin : g_hi
            assign key_b[g] = i_key_hi[8*(g-8) +: 8];
        end else begin : g_zero
            assign key_b[g] = 8'h00;
        end
    end

    always_comb begin
        for (int i = 0; i < KEY_BYTES - 1; i++) begin
            n_win[i] = r_win[i+1];
        end
        n_win[KEY_BYTES-1] = i_item.text_byte;
        n_fill = (r_fill == LW'(KEY_BYTES)) ? r_fill : r_fill + LW'(1);
        len = ({1'b0, i_key_len} > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : {1'b0, i_key_len};
        match = 1'b1;
        idx = '0;
        // newest byte sits at the top of the window, key is right-aligned to it
        for (int p = 0; p < KEY_BYTES; p++) begin
            idx = 6'(p) + len - 6'(KEY_BYTES);
            if (6'(p) >= 6'(KEY_BYTES) - len) begin
                if (n_win[p] != key_b[KIW'(idx)]) begin
                    match = 1'b0;
                end
            end
        end
        hx = hex_class(i_item.text_byte);
        o_tok.ch        = i_item.text_byte;
        o_tok.last      = i_item.text_last;
        o_tok.hit       = match && (6'(n_fill) >= len);
        o_tok.key_empty = (len == 6'd0);
        o_tok.hex_ok    = hx[4];
        o_tok.hex_val   = hx[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= i_item.text_last ? '0 : n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

/* rtl/jsfx_tokq.sv */
// four-entry queue of classified bytes between front and back
// depends on jsfx_pkg
`timescale 1ns / 1ps

module jsfx_tokq import jsfx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_tok i_tok,
    input  logic i_rd,
    output t_tok o_tok,
    output logic o_full,
    output logic o_empty
);

    t_tok       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_wr) - 3'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_tok;
        end
    end

endmodule

/* rtl/jsfx_back.sv */
// back end: string value decoder with surrogate look-ahead, replay and result buffer
// depends on jsfx_pkg
`timescale 1ns / 1ps

module jsfx_back import jsfx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok      i_tok,
    input  logic      i_tok_valid,
    output logic      o_tok_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    t_phase     r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0] r_hcnt, n_hcnt;
    logic [9:0] r_hi, n_hi;
    t_tok       r_la [6];
    t_tok       n_la [6];
    logic [2:0] r_la_cnt, n_la_cnt;
    t_tok       r_rp [6];
    logic [2:0] r_rp_len, n_rp_len, r_rp_idx, n_rp_idx;
    logic       r_rp_last, n_rp_last;
    t_out_item  r_pend [5];
    t_out_item  n_pend [5];
    t_out_item  ent [5];
    logic [2:0] r_pcnt, n_pcnt;

    logic        rp_act, pop_ok, can_step, step, rp_start, fail, ok, end_req, txt_rst;
    t_end_reason end_rsn;
    t_tok        tok;
    t_utf8       m;
    logic [15:0] acc_next, low16;
    logic [20:0] pair_cp;

    assign rp_act   = (r_rp_idx != r_rp_len);
    assign pop_ok   = i_pop && (r_pcnt != 3'd0);
    assign can_step = (r_pcnt == 3'd0) || ((r_pcnt == 3'd1) && pop_ok);
    assign step     = can_step && (rp_act || i_tok_valid);
    assign o_tok_rd = step && !rp_act;
    assign o_empty  = (r_pcnt == 3'd0);
    assign o_result = r_pend[0];

    always_comb begin
        tok = i_tok;
        if (rp_act) begin
            tok = r_rp[r_rp_idx];
            tok.last = r_rp_last && (r_rp_idx == r_rp_len - 3'd1);
        end
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_hcnt    = r_hcnt;
        n_hi      = r_hi;
        n_la      = r_la;
        n_la_cnt  = r_la_cnt;
        n_rp_len  = r_rp_len;
        n_rp_idx  = rp_act ? r_rp_idx + 3'd1 : r_rp_idx;
        n_rp_last = r_rp_last;
        rp_start  = 1'b0;
        fail      = 1'b0;
        ok        = 1'b0;
        end_req   = 1'b0;
        end_rsn   = END_QUOTE;
        txt_rst   = 1'b0;
        m         = '0;
        acc_next  = {r_acc[11:0], tok.hex_val};
        low16     = {r_la[2].hex_val, r_la[3].hex_val, r_la[4].hex_val, tok.hex_val};
        pair_cp   = SUPP_BASE + {1'b0, r_hi, low16[9:0]};

        case (r_phase)
            PH_SEARCH: begin
                if (tok.key_empty) begin
                    n_phase = (tok.ch == CH_COLON) ? PH_QUOTE : PH_COLON;
                end else if (tok.hit) begin
                    n_phase = PH_COLON;
                end
            end
            PH_COLON: begin
                if (tok.ch == CH_COLON) begin
                    n_phase = PH_QUOTE;
                end
            end
            PH_QUOTE: begin
                if (tok.ch == CH_QUOTE) begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (tok.ch == CH_QUOTE) begin
                    end_req = 1'b1;
                    end_rsn = END_QUOTE;
                    n_phase = PH_DONE;
                end else if (tok.ch == CH_BSLASH) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    m.n    = 3'd1;
                    m.b[0] = tok.ch;
                end
            end
            PH_ESCAPE: begin
                n_phase = PH_VALUE;
                m.n     = 3'd1;
                case (tok.ch)
                    CH_B: m.b[0] = 8'h08;
                    CH_F: m.b[0] = 8'h0c;
                    CH_N: m.b[0] = 8'h0a;
                    CH_R: m.b[0] = 8'h0d;
                    CH_T: m.b[0] = 8'h09;
                    CH_U: begin
                        m.n     = 3'd0;
                        n_acc   = '0;
                        n_hcnt  = '0;
                        n_phase = PH_HEX;
                    end
                    default: m.b[0] = tok.ch;
                endcase
            end
            PH_HEX: begin
                if (!tok.hex_ok) begin
                    end_req = 1'b1;
                    end_rsn = END_BADHEX;
                    n_phase = PH_DONE;
                end else begin
                    n_acc = acc_next;
                    if (r_hcnt == 2'd3) begin
                        n_hcnt = '0;
                        if (acc_next >= HI_SURR_MIN && acc_next <= HI_SURR_MAX) begin
                            n_hi     = acc_next[9:0];
                            n_la_cnt = '0;
                            n_phase  = PH_LOOK;
                        end else begin
                            n_phase = PH_VALUE;
                            m       = utf8_enc({5'b0, acc_next});
                        end
                    end else begin
                        n_hcnt = r_hcnt + 2'd1;
                    end
                end
            end
            PH_LOOK: begin
                n_la[r_la_cnt] = tok;
                if (r_la_cnt == 3'd0) begin
                    ok = (tok.ch == CH_BSLASH);
                end else if (r_la_cnt == 3'd1) begin
                    ok = (tok.ch == CH_U);
                end else begin
                    ok = tok.hex_ok;
                end
                if (!ok) begin
                    fail = 1'b1;
                end else if (r_la_cnt == 3'd5) begin
                    if (low16 >= LO_SURR_MIN && low16 <= LO_SURR_MAX) begin
                        m        = utf8_enc(pair_cp);
                        n_phase  = PH_VALUE;
                        n_la_cnt = '0;
                    end else begin
                        fail = 1'b1;
                    end
                end else begin
                    n_la_cnt = r_la_cnt + 3'd1;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (fail) begin
            // lone high surrogate goes out, gathered bytes are decoded again
            m         = utf8_enc({5'b0, 6'b110110, n_hi});
            n_phase   = PH_VALUE;
            n_rp_len  = r_la_cnt + 3'd1;
            n_la_cnt  = '0;
            rp_start  = 1'b1;
            n_rp_last = tok.last;
        end else if (tok.last) begin
            if (n_phase == PH_LOOK) begin
                m       = utf8_enc({5'b0, 6'b110110, n_hi});
                n_phase = PH_VALUE;
                if (n_la_cnt != 3'd0) begin
                    n_rp_len  = n_la_cnt;
                    n_la_cnt  = '0;
                    rp_start  = 1'b1;
                    n_rp_last = 1'b1;
                end else begin
                    end_req = 1'b1;
                    end_rsn = END_TEXT;
                    txt_rst = 1'b1;
                end
            end else begin
                if (n_phase != PH_DONE) begin
                    end_req = 1'b1;
                    if (n_phase == PH_SEARCH || n_phase == PH_COLON
                            || n_phase == PH_QUOTE) begin
                        end_rsn = END_NOTFOUND;
                    end else if (n_phase == PH_HEX) begin
                        end_rsn = END_BADHEX;
                    end else begin
                        end_rsn = END_TEXT;
                    end
                end
                txt_rst = 1'b1;
            end
        end

        if (rp_start) begin
            n_rp_idx = '0;
        end
        if (txt_rst) begin
            n_phase  = PH_SEARCH;
            n_acc    = '0;
            n_hcnt   = '0;
            n_hi     = '0;
            n_la_cnt = '0;
        end

        for (int i = 0; i < 5; i++) begin
            ent[i] = '0;
            if (3'(i) < m.n) begin
                ent[i].out_byte   = m.b[i];
                ent[i].byte_valid = 1'b1;
            end else if (3'(i) == m.n && end_req) begin
                ent[i].end_of_value = 1'b1;
                ent[i].end_reason   = end_rsn;
            end
        end

        n_pend = r_pend;
        n_pcnt = r_pcnt;
        if (pop_ok) begin
            for (int i = 0; i < 4; i++) begin
                n_pend[i] = r_pend[i+1];
            end
            n_pcnt = r_pcnt - 3'd1;
        end
        if (step) begin
            n_pend = ent;
            n_pcnt = m.n + 3'(end_req);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_hcnt    <= '0;
            r_la_cnt  <= '0;
            r_rp_len  <= '0;
            r_rp_idx  <= '0;
            r_rp_last <= 1'b0;
            r_pcnt    <= '0;
        end else begin
            r_pcnt <= n_pcnt;
            if (step) begin
                r_phase   <= n_phase;
                r_hcnt    <= n_hcnt;
                r_la_cnt  <= n_la_cnt;
                r_rp_len  <= n_rp_len;
                r_rp_idx  <= n_rp_idx;
                r_rp_last <= n_rp_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (step) begin
            r_acc <= n_acc;
            r_hi  <= n_hi;
            r_la  <= n_la;
            if (rp_start) begin
                r_rp <= n_la;
            end
        end
    end

endmodule

/* rtl/jsfx_checker.sv */
// port-level checks for the json string extractor, bound to the top level
// depends on jsfx_pkg and json_string_field_extractor
`timescale 1ns / 1ps

module jsfx_port_checks import jsfx_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_kind_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.byte_valid != o_result.end_of_value))
        else $error("result is neither a byte nor an end marker");

    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.end_of_value && o_result.out_byte == 8'h00)
            || (o_result.byte_valid && o_result.end_reason == 2'd0)))
        else $error("unused result field not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind json_string_field_extractor jsfx_port_checks u_jsfx_port_checks (.*);
